// ===== design/lrd_pkg.sv =====
// ============================================================================
// lrd_pkg: shared types and constants of the log record deframer
// Phase codes, byte role codes, record type codes and the request record
// that travels from the parser front through the queue to the output stage.
// ============================================================================
package lrd_pkg;

    typedef enum logic [3:0] {
        PH_INDEX   = 4'd0,
        PH_TYPE    = 4'd1,
        PH_TIME    = 4'd2,
        PH_SUB     = 4'd3,
        PH_SIZE    = 4'd4,
        PH_SIZE_HI = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_TEXT    = 4'd7,
        PH_ENDED   = 4'd8
    } phase_t;

    typedef logic [2:0] role_t;

    localparam role_t ROLE_INDEX    = 3'd0;
    localparam role_t ROLE_TYPE     = 3'd1;
    localparam role_t ROLE_TIME     = 3'd2;
    localparam role_t ROLE_SUBTYPE  = 3'd3;
    localparam role_t ROLE_SIZE     = 3'd4;
    localparam role_t ROLE_PAYLOAD  = 3'd5;
    localparam role_t ROLE_TEXT_END = 3'd6;
    localparam role_t ROLE_IGNORED  = 3'd7;

    localparam logic [7:0] TYPE_TEXT_TS    = 8'd0;
    localparam logic [7:0] TYPE_TEXT       = 8'd1;
    localparam logic [7:0] TYPE_BIN8_TS    = 8'd2;
    localparam logic [7:0] TYPE_BIN8       = 8'd3;
    localparam logic [7:0] TYPE_BIN16_TS   = 8'd4;
    localparam logic [7:0] TYPE_BIN16      = 8'd5;

    localparam logic [15:0] TIME_BYTES  = 16'd8;
    localparam logic [31:0] END_INDEX   = 32'hFFFF_FFFF;
    localparam logic [15:0] OFFSET_MAX  = 16'hFFFF;

    // One classified byte; ctx marks bytes that carry the record context.
    typedef struct packed {
        role_t       role;
        logic [7:0]  value;
        logic [31:0] index;
        logic [7:0]  rtype;
        logic        ctx;
        logic [7:0]  subtype;
        logic [15:0] length;
        logic [15:0] offset;
        logic        last;
        logic        eol;
        logic        unk;
    } byte_req_t;

    function automatic logic type_has_time(input logic [7:0] t);
        return (t == TYPE_TEXT_TS) || (t == TYPE_BIN8_TS) || (t == TYPE_BIN16_TS);
    endfunction

endpackage

// ===== design/lrd_front.sv =====
// ============================================================================
// lrd_front: record parser
// Tracks the record phase and classifies each accepted byte into a request.
// ============================================================================
module lrd_front
    import lrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    input  logic      q_full,
    output logic      q_push,
    output byte_req_t q_req
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  sub_reg, sub_next;
    logic [15:0] len_reg, len_next;

    logic        accept;
    logic [15:0] count_inc;
    logic [16:0] count_inc_wide;
    logic [15:0] len_full;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;

    assign count_inc      = count_reg + 16'd1;
    assign count_inc_wide = {1'b0, count_reg} + 17'd1;
    assign len_full       = {in_byte, len_reg[7:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INDEX;
            count_reg <= '0;
            shift_reg <= '0;
            type_reg  <= '0;
            sub_reg   <= '0;
            len_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            type_reg  <= type_next;
            sub_reg   <= sub_next;
            len_reg   <= len_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        type_next  = type_reg;
        sub_next   = sub_reg;
        len_next   = len_reg;

        q_req         = '0;
        q_req.value   = in_byte;
        q_req.ctx     = 1'b1;

        case (phase_reg)
            PH_ENDED: begin
                q_req.role  = ROLE_IGNORED;
                q_req.index = END_INDEX;
                q_req.eol   = 1'b1;
                q_req.ctx   = 1'b0;
            end
            PH_TYPE: begin
                q_req.role = ROLE_TYPE;
                type_next  = in_byte;
                sub_next   = '0;
                len_next   = '0;
                count_next = '0;
                if (type_has_time(in_byte)) begin
                    phase_next = PH_TIME;
                end else if (in_byte == TYPE_TEXT) begin
                    phase_next = PH_TEXT;
                end else if (in_byte == TYPE_BIN8 || in_byte == TYPE_BIN16) begin
                    phase_next = PH_SUB;
                end else begin
                    q_req.last = 1'b1;
                    q_req.unk  = 1'b1;
                    phase_next = PH_INDEX;
                end
            end
            PH_TIME: begin
                q_req.role = ROLE_TIME;
                count_next = count_inc;
                if (count_inc >= TIME_BYTES) begin
                    count_next = '0;
                    phase_next = (type_reg == TYPE_TEXT_TS) ? PH_TEXT : PH_SUB;
                end
            end
            PH_SUB: begin
                q_req.role    = ROLE_SUBTYPE;
                sub_next      = in_byte;
                q_req.subtype = in_byte;
                phase_next    = PH_SIZE;
            end
            PH_SIZE: begin
                q_req.role    = ROLE_SIZE;
                q_req.subtype = sub_reg;
                len_next      = {8'd0, in_byte};
                if (type_reg == TYPE_BIN16_TS || type_reg == TYPE_BIN16) begin
                    phase_next = PH_SIZE_HI;
                end else begin
                    q_req.length = {8'd0, in_byte};
                    count_next   = '0;
                    if (in_byte == 8'd0) begin
                        q_req.last = 1'b1;
                        phase_next = PH_INDEX;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_SIZE_HI: begin
                q_req.role    = ROLE_SIZE;
                q_req.subtype = sub_reg;
                len_next      = len_full;
                q_req.length  = len_full;
                count_next    = '0;
                if (len_full == 16'd0) begin
                    q_req.last = 1'b1;
                    phase_next = PH_INDEX;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                q_req.role    = ROLE_PAYLOAD;
                q_req.subtype = sub_reg;
                q_req.length  = len_reg;
                q_req.offset  = count_reg;
                if (count_inc_wide >= {1'b0, len_reg}) begin
                    q_req.last = 1'b1;
                    count_next = '0;
                    phase_next = PH_INDEX;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_TEXT: begin
                q_req.offset = count_reg;
                if (in_byte == 8'd0) begin
                    q_req.role = ROLE_TEXT_END;
                    q_req.last = 1'b1;
                    count_next = '0;
                    phase_next = PH_INDEX;
                end else begin
                    q_req.role = ROLE_PAYLOAD;
                    if (count_reg != OFFSET_MAX) begin
                        count_next = count_inc;
                    end
                end
            end
            default: begin
                // index bytes, least significant first
                q_req.role = ROLE_INDEX;
                q_req.ctx  = 1'b0;
                case (count_reg[1:0])
                    2'd0:    shift_next = {24'd0, in_byte};
                    2'd1:    shift_next = {shift_reg[31:16], in_byte, shift_reg[7:0]};
                    2'd2:    shift_next = {shift_reg[31:24], in_byte, shift_reg[15:0]};
                    default: shift_next = {in_byte, shift_reg[23:0]};
                endcase
                q_req.index = shift_next;
                if (count_reg[1:0] == 2'd3) begin
                    count_next = '0;
                    if (shift_next == END_INDEX) begin
                        phase_next = PH_ENDED;
                        q_req.eol  = 1'b1;
                    end else begin
                        phase_next = PH_TYPE;
                    end
                end else begin
                    phase_next = PH_INDEX;
                    count_next = {14'd0, count_reg[1:0]} + 16'd1;
                end
            end
        endcase

        // context fields follow the updated record registers
        if (q_req.ctx) begin
            q_req.index = shift_next;
            q_req.rtype = type_next;
        end
    end

    a_ended_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ENDED |=> phase_reg == PH_ENDED)
        else $error("parser left the ended phase");

    a_ignored_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_req.role == ROLE_IGNORED |-> q_req.eol && !q_req.last)
        else $error("ignored byte without end of log");

endmodule

// ===== design/lrd_queue.sv =====
// ============================================================================
// lrd_queue: request queue
// Small register FIFO that decouples the parser from the output stage.
// ============================================================================
module lrd_queue
    import lrd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  byte_req_t push_req,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output byte_req_t pop_req
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    byte_req_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_req = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CW'(1);
                2'b01:   count_reg <= count_reg - CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push && !do_pop |=> !empty)
        else $error("queue empty after push");

endmodule

// ===== design/lrd_back.sv =====
// ============================================================================
// lrd_back: output stage
// Takes requests from the queue, expands them into result fields and holds
// them in the output register until the receiver takes them.
// ============================================================================
module lrd_back
    import lrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  byte_req_t   q_req,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_role,
    output logic [7:0]  out_value,
    output logic [31:0] out_index,
    output logic [7:0]  out_type,
    output logic        out_has_time,
    output logic [7:0]  out_subtype,
    output logic [15:0] out_length,
    output logic [15:0] out_offset,
    output logic        out_last,
    output logic        out_eol,
    output logic        out_unk
);

    logic        valid_reg;
    byte_req_t   req_reg;
    logic        time_reg;
    logic        load;

    assign load  = !q_empty && (!valid_reg || out_ready);
    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            req_reg  <= q_req;
            time_reg <= q_req.ctx && type_has_time(q_req.rtype);
        end
    end

    assign out_valid    = valid_reg;
    assign out_role     = req_reg.role;
    assign out_value    = req_reg.value;
    assign out_index    = req_reg.index;
    assign out_type     = req_reg.rtype;
    assign out_has_time = time_reg;
    assign out_subtype  = req_reg.subtype;
    assign out_length   = req_reg.length;
    assign out_offset   = req_reg.offset;
    assign out_last     = req_reg.last;
    assign out_eol      = req_reg.eol;
    assign out_unk      = req_reg.unk;

endmodule

// ===== design/log_record_deframer_core.sv =====
// ============================================================================
// log_record_deframer_core: labels each byte of a log record stream
// Parser front, request queue and output register, joined by valid/ready.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data_byte carry the raw log stream, one byte per
//   request. m_valid/m_ready carry one labeled result per input byte, in
//   order: role, the byte itself, and the context of the record it is in
//   (index, type, timestamp flag, subtype, declared length, offset within
//   payload or text, record end, end of log, unknown type).
//   Throughput is one byte per cycle while the queue is not full. The
//   per-byte decision is a single phase update in the parser front, so
//   bytes can follow back to back. The accept edge writes the request into
//   the queue; the output register loads it from there once the register is
//   free, and m_valid rises when it holds the result.
//   When the receiver stalls, the output register holds its result and the
//   queue absorbs up to QUEUE_DEPTH more bytes; s_ready drops only once the
//   queue is full.
//   After an index of all ones every further byte is reported as ignored
//   until reset. Reset (aresetn low, synchronous) returns the parser to the
//   first index byte, empties the queue and clears m_valid.
// ============================================================================
module log_record_deframer_core
    import lrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_byte_role,
    output logic [7:0]  m_byte_value,
    output logic [31:0] m_record_index,
    output logic [7:0]  m_record_type,
    output logic        m_has_time,
    output logic [7:0]  m_record_subtype,
    output logic [15:0] m_payload_length,
    output logic [15:0] m_payload_offset,
    output logic        m_record_last,
    output logic        m_end_of_log,
    output logic        m_unknown_type
);

    byte_req_t push_req, pop_req;
    logic      push, pop, q_full, q_empty;

    // Front: classify each byte and advance the record phase.
    lrd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_byte  (s_data_byte),
        .q_full   (q_full),
        .q_push   (push),
        .q_req    (push_req)
    );

    // Queue: hold classified requests while the receiver stalls.
    lrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_req  (pop_req)
    );

    // Back: expand requests into result fields and drive the result channel.
    lrd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_req        (pop_req),
        .q_pop        (pop),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_role     (m_byte_role),
        .out_value    (m_byte_value),
        .out_index    (m_record_index),
        .out_type     (m_record_type),
        .out_has_time (m_has_time),
        .out_subtype  (m_record_subtype),
        .out_length   (m_payload_length),
        .out_offset   (m_payload_offset),
        .out_last     (m_record_last),
        .out_eol      (m_end_of_log),
        .out_unk      (m_unknown_type)
    );

    a_ignored_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_role == ROLE_IGNORED |-> m_record_index == END_INDEX)
        else $error("ignored byte without end marker index");

endmodule
